[src/m4vt_pkg.sv]
// Shared types, constants and helpers for the 4x4 matrix-vector transform.
`timescale 1ns / 1ps
package m4vt_pkg;

    localparam int DIM_DEF    = 4;
    localparam int FRAC_DEF   = 16;
    localparam int NUM_LANES  = 4;
    localparam int ELEM_W     = 32;
    localparam int IDX_W      = 2;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = NUM_LANES * ELEM_W;

    typedef logic signed [ELEM_W-1:0] t_lane;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_XFORM = 1'b1
    } t_action;

    localparam t_lane LANE_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam t_lane LANE_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    function automatic int eff_dim(int d);
        return (d < NUM_LANES) ? d : NUM_LANES;
    endfunction

    function automatic int sum_width(int d);
        return PROD_W + $clog2(eff_dim(d));
    endfunction

endpackage

[src/m4vt_store.sv]
// Matrix element registers with single-element load writes.
`timescale 1ns / 1ps
module m4vt_store #(
    parameter int DIM = m4vt_pkg::DIM_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [m4vt_pkg::IDX_W-1:0] i_row,
    input  logic [m4vt_pkg::IDX_W-1:0] i_col,
    input  m4vt_pkg::t_lane        i_value,
    output m4vt_pkg::t_lane        o_matrix [m4vt_pkg::eff_dim(DIM)][m4vt_pkg::eff_dim(DIM)]
);
    import m4vt_pkg::*;

    localparam int EFF = eff_dim(DIM);

    t_lane r_matrix [EFF][EFF];

    for (genvar gr = 0; gr < EFF; gr++) begin : g_row
        for (genvar gc = 0; gc < EFF; gc++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_matrix[gr][gc] <= '0;
                end else if (i_wr_en && i_row == IDX_W'(gr) && i_col == IDX_W'(gc)) begin
                    r_matrix[gr][gc] <= i_value;
                end
            end
            assign o_matrix[gr][gc] = r_matrix[gr][gc];
        end
    end

endmodule

[src/m4vt_mult_stage.sv]
// First pipeline stage: all element-by-component products, registered.
`timescale 1ns / 1ps
module m4vt_mult_stage #(
    parameter int DIM = m4vt_pkg::DIM_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  m4vt_pkg::t_lane i_vec [m4vt_pkg::NUM_LANES],
    input  m4vt_pkg::t_lane i_matrix [m4vt_pkg::eff_dim(DIM)][m4vt_pkg::eff_dim(DIM)],
    output logic            o_valid,
    input  logic            i_ready,
    output m4vt_pkg::t_prod o_prod [m4vt_pkg::eff_dim(DIM)][m4vt_pkg::eff_dim(DIM)]
);
    import m4vt_pkg::*;

    localparam int EFF = eff_dim(DIM);

    logic  r_valid;
    t_prod r_prod [EFF][EFF];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    for (genvar gr = 0; gr < EFF; gr++) begin : g_row
        for (genvar gc = 0; gc < EFF; gc++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (o_ready && i_valid) begin
                    r_prod[gr][gc] <= t_prod'(i_matrix[gr][gc]) * t_prod'(i_vec[gc]);
                end
            end
            assign o_prod[gr][gc] = r_prod[gr][gc];
        end
    end

endmodule

[src/m4vt_sum_stage.sv]
// Second pipeline stage: exact row sums of the products.
`timescale 1ns / 1ps
module m4vt_sum_stage #(
    parameter int DIM = m4vt_pkg::DIM_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  m4vt_pkg::t_prod i_prod [m4vt_pkg::eff_dim(DIM)][m4vt_pkg::eff_dim(DIM)],
    output logic            o_valid,
    input  logic            i_ready,
    output logic signed [m4vt_pkg::sum_width(DIM)-1:0] o_sum [m4vt_pkg::eff_dim(DIM)]
);
    import m4vt_pkg::*;

    localparam int EFF   = eff_dim(DIM);
    localparam int SUM_W = sum_width(DIM);

    logic                    r_valid;
    logic signed [SUM_W-1:0] r_sum [EFF];
    logic signed [SUM_W-1:0] n_sum [EFF];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_comb begin
        for (int r = 0; r < EFF; r++) begin
            n_sum[r] = '0;
            for (int c = 0; c < EFF; c++) begin
                n_sum[r] = n_sum[r] + SUM_W'(i_prod[r][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

[src/m4vt_sat_stage.sv]
// Third pipeline stage: fraction shift, saturation and the output register.
`timescale 1ns / 1ps
module m4vt_sat_stage #(
    parameter int DIM       = m4vt_pkg::DIM_DEF,
    parameter int FRAC_BITS = m4vt_pkg::FRAC_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic signed [m4vt_pkg::sum_width(DIM)-1:0] i_sum [m4vt_pkg::eff_dim(DIM)],
    output logic            o_valid,
    input  logic            i_ready,
    output m4vt_pkg::t_lane o_lane [m4vt_pkg::NUM_LANES],
    output logic            o_sat
);
    import m4vt_pkg::*;

    localparam int EFF   = eff_dim(DIM);
    localparam int SUM_W = sum_width(DIM);
    localparam int SH_W  = SUM_W - FRAC_BITS;

    logic              r_valid;
    t_lane             r_lane [NUM_LANES];
    logic              r_sat;
    t_lane             n_lane [NUM_LANES];
    logic              n_sat;
    logic [SH_W-1:0]   sh;
    logic              ovf;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_comb begin
        n_sat = 1'b0;
        sh    = '0;
        ovf   = 1'b0;
        for (int r = 0; r < NUM_LANES; r++) begin
            n_lane[r] = '0;
            if (r < EFF) begin
                sh  = i_sum[r][SUM_W-1:FRAC_BITS];
                ovf = !(&sh[SH_W-1:ELEM_W-1]) && (|sh[SH_W-1:ELEM_W-1]);
                if (ovf) begin
                    n_lane[r] = sh[SH_W-1] ? LANE_MIN : LANE_MAX;
                end else begin
                    n_lane[r] = sh[ELEM_W-1:0];
                end
                n_sat = n_sat | ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lane <= n_lane;
            r_sat  <= n_sat;
        end
    end

    assign o_lane = r_lane;
    assign o_sat  = r_sat;

    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_sat) |->
            (r_lane[0] == LANE_MAX || r_lane[0] == LANE_MIN ||
             r_lane[1] == LANE_MAX || r_lane[1] == LANE_MIN ||
             r_lane[2] == LANE_MAX || r_lane[2] == LANE_MIN ||
             r_lane[3] == LANE_MAX || r_lane[3] == LANE_MIN))
        else $error("Saturation flag set with no clipped component.");

endmodule

[src/matrix4_vector_transform.sv]
// Top level of the pipelined 4x4 Q16.16 matrix-vector transform.
//
//  Channel  Dir  Payload
//  s_axis   in   tdata: row, col, element, x, y, z, w; tuser: action
//  m_axis   out  tdata: out x, y, z, w; tuser: saturated
//
// One request is accepted per cycle while s_axis_tready is high; a transform result
// passes through the product, row sum and saturation registers in that order.
// A load request updates the matrix at its accept edge and is seen by the
// transform request accepted in the next cycle; loads give no result.
// Reset is synchronous and clears the matrix and all stage valid bits.
// Each stage holds its item while the next one stalls, so s_axis_tready
// drops only when all three stages are full and m_axis_tready is low.
`timescale 1ns / 1ps
module matrix4_vector_transform #(
    parameter int DIM       = m4vt_pkg::DIM_DEF,
    parameter int FRAC_BITS = m4vt_pkg::FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // row_index, col_index, element_value, vec_x, vec_y, vec_z, vec_w, zero fill
    input  logic [m4vt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // action
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_x, out_y, out_z, out_w
    output logic [m4vt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // saturated
    output logic [0:0]                        m_axis_tuser
);
    import m4vt_pkg::*;

    localparam int EFF   = eff_dim(DIM);
    localparam int SUM_W = sum_width(DIM);
    localparam int ELEM_LSB = 2 * IDX_W;
    localparam int VEC_LSB  = ELEM_LSB + ELEM_W;

    logic                    in_accept;
    t_action                 action;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    t_lane                   element_value;
    t_lane                   vec [NUM_LANES];
    t_lane                   matrix [EFF][EFF];
    logic                    mult_valid;
    logic                    sum_ready;
    t_prod                   prod [EFF][EFF];
    logic                    sum_valid;
    logic                    sat_ready;
    logic signed [SUM_W-1:0] sum [EFF];
    t_lane                   lane [NUM_LANES];
    logic                    sat;

    assign action        = t_action'(s_axis_tuser[0]);
    assign row_index     = s_axis_tdata[IDX_W-1:0];
    assign col_index     = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign element_value = s_axis_tdata[ELEM_LSB +: ELEM_W];
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    for (genvar gk = 0; gk < NUM_LANES; gk++) begin : g_vec
        assign vec[gk] = s_axis_tdata[VEC_LSB + gk*ELEM_W +: ELEM_W];
        assign m_axis_tdata[gk*ELEM_W +: ELEM_W] = lane[gk];
    end

    m4vt_store #(
        .DIM (DIM)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (in_accept && action == ACT_LOAD),
        .i_row    (row_index),
        .i_col    (col_index),
        .i_value  (element_value),
        .o_matrix (matrix)
    );

    m4vt_mult_stage #(
        .DIM (DIM)
    ) u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid && action == ACT_XFORM),
        .o_ready  (s_axis_tready),
        .i_vec    (vec),
        .i_matrix (matrix),
        .o_valid  (mult_valid),
        .i_ready  (sum_ready),
        .o_prod   (prod)
    );

    m4vt_sum_stage #(
        .DIM (DIM)
    ) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mult_valid),
        .o_ready (sum_ready),
        .i_prod  (prod),
        .o_valid (sum_valid),
        .i_ready (sat_ready),
        .o_sum   (sum)
    );

    m4vt_sat_stage #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .o_ready (sat_ready),
        .i_sum   (sum),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_lane  (lane),
        .o_sat   (sat)
    );

    assign m_axis_tuser = sat;

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && action == ACT_LOAD) |=> !mult_valid)
        else $error("Load request entered the arithmetic pipeline.");

    a_xform_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && action == ACT_XFORM) |=> mult_valid)
        else $error("Accepted transform request was lost at the first stage.");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (mult_valid && sum_valid && m_axis_tvalid && !m_axis_tready))
        else $error("Input stalled while the pipeline had room.");

endmodule

[verif/tb_matrix4_vector_transform.sv]
// Self-checking stream testbench for the 4x4 Q16.16 matrix-vector transform.
`timescale 1ns / 1ps
module tb_matrix4_vector_transform;
    import m4vt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic signed [65:0] SUM_HI = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] SUM_LO = -66'sh0_8000_0000;
    localparam t_lane ONE_Q16 = 32'sh0001_0000;

    typedef struct packed {
        t_action                     action;
        logic [IDX_W-1:0]            row;
        logic [IDX_W-1:0]            col;
        t_lane                       element;
        logic [NUM_LANES-1:0][31:0]  vec;
    } t_xform_request;

    typedef struct packed {
        logic [NUM_LANES-1:0][31:0]  lane;
        logic                        saturated;
    } t_xform_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // row_index, col_index, element_value, vec_x, vec_y, vec_z, vec_w, zero fill
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    // action
    logic [0:0]              s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // out_x, out_y, out_z, out_w
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    // saturated
    logic [0:0]              m_axis_tuser;

    t_lane          matrix_coeff [NUM_LANES][NUM_LANES];
    t_xform_result  pending_results [$];
    t_xform_result  oldest_result;
    int             mismatch_count = 0;
    int             src_idle_pct = 0;
    int             snk_stall_pct = 0;
    int             cycle_count = 0;
    string          lane_names [NUM_LANES] = '{"out_x", "out_y", "out_z", "out_w"};

    matrix4_vector_transform dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Each row sums four exact 64-bit products, floors by 2^16 and saturates.
    function automatic t_xform_result predict_transform(t_xform_request req);
        t_xform_result       res;
        logic signed [65:0]  acc;
        t_prod               prod;
        res = '0;
        for (int r = 0; r < NUM_LANES; r++) begin
            acc = '0;
            for (int c = 0; c < NUM_LANES; c++) begin
                prod = t_prod'(matrix_coeff[r][c]) * t_prod'($signed(req.vec[c]));
                acc += 66'(prod);
            end
            acc = acc >>> FRAC_DEF;
            if (acc > SUM_HI) begin
                res.lane[r] = LANE_MAX;
                res.saturated = 1'b1;
            end else if (acc < SUM_LO) begin
                res.lane[r] = LANE_MIN;
                res.saturated = 1'b1;
            end else begin
                res.lane[r] = acc[31:0];
            end
        end
        return res;
    endfunction

    function automatic void record_request(t_xform_request req);
        if (req.action == ACT_LOAD) begin
            matrix_coeff[req.row][req.col] = req.element;
        end else begin
            pending_results.push_back(predict_transform(req));
        end
    endfunction

    function automatic t_xform_request make_request(t_action action, int row, int col,
                                                    t_lane element, t_lane x, t_lane y,
                                                    t_lane z, t_lane w);
        t_xform_request req;
        req.action  = action;
        req.row     = IDX_W'(row);
        req.col     = IDX_W'(col);
        req.element = element;
        req.vec[0]  = x;
        req.vec[1]  = y;
        req.vec[2]  = z;
        req.vec[3]  = w;
        return req;
    endfunction

    function automatic t_lane rand_q16();
        case ($urandom_range(3))
            0: return t_lane'($urandom);
            1: return t_lane'($urandom_range(262143)) - t_lane'(131072);
            2: return t_lane'($urandom_range(33554431)) - t_lane'(16777216);
            default: begin
                case ($urandom_range(4))
                    0: return LANE_MAX;
                    1: return LANE_MIN;
                    2: return t_lane'(0);
                    3: return t_lane'(-1);
                    default: return ONE_Q16;
                endcase
            end
        endcase
    endfunction

    function automatic t_xform_request rand_request(int load_pct);
        t_xform_request req;
        req.action  = ($urandom_range(99) < load_pct) ? ACT_LOAD : ACT_XFORM;
        req.row     = IDX_W'($urandom_range(3));
        req.col     = IDX_W'($urandom_range(3));
        req.element = rand_q16();
        for (int k = 0; k < NUM_LANES; k++) begin
            req.vec[k] = rand_q16();
        end
        return req;
    endfunction

    task automatic send_request(t_xform_request req);
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.action;
        s_axis_tdata  <= {4'b0, req.vec[3], req.vec[2], req.vec[1], req.vec[0],
                          req.element, req.col, req.row};
        do @(posedge i_clk); while (!s_axis_tready);
        record_request(req);
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: tdata %h, saturated %b", m_axis_tdata,
                       m_axis_tuser[0]);
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                for (int k = 0; k < NUM_LANES; k++) begin
                    if (m_axis_tdata[k*ELEM_W +: ELEM_W] !== oldest_result.lane[k]) begin
                        $error("%s: expected %0d, got %0d", lane_names[k],
                               $signed(oldest_result.lane[k]),
                               $signed(m_axis_tdata[k*ELEM_W +: ELEM_W]));
                        mismatch_count++;
                    end
                end
                if (m_axis_tuser[0] !== oldest_result.saturated) begin
                    $error("saturated: expected %b, got %b", oldest_result.saturated,
                           m_axis_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_cleared_store();
        send_request(make_request(ACT_XFORM, 0, 0, 0, LANE_MAX, LANE_MIN, -1, 1));
        wait_until_drained();
    endtask

    // Opposite full-scale products force both saturation directions, and a
    // tiny negative product checks that the shift floors toward minus infinity.
    task automatic test_extreme_products();
        send_request(make_request(ACT_LOAD, 0, 0, LANE_MAX, 0, 0, 0, 0));
        send_request(make_request(ACT_LOAD, 0, 1, LANE_MAX, 0, 0, 0, 0));
        send_request(make_request(ACT_LOAD, 1, 0, LANE_MIN, 0, 0, 0, 0));
        send_request(make_request(ACT_LOAD, 1, 1, LANE_MIN, 0, 0, 0, 0));
        send_request(make_request(ACT_LOAD, 2, 2, -1, 0, 0, 0, 0));
        send_request(make_request(ACT_LOAD, 3, 3, ONE_Q16, 0, 0, 0, 0));
        send_request(make_request(ACT_LOAD, 3, 2, LANE_MIN, 0, 0, 0, 0));
        send_request(make_request(ACT_XFORM, 0, 0, 0, LANE_MAX, LANE_MAX, 1, LANE_MIN));
        send_request(make_request(ACT_XFORM, 0, 0, 0, LANE_MIN, LANE_MIN, LANE_MIN,
                                  LANE_MIN));
        send_request(make_request(ACT_XFORM, 0, 0, 0, 1, 0, 0, 0));
        send_request(make_request(ACT_XFORM, 0, 0, 0, -1, -1, -1, -1));
        send_request(make_request(ACT_XFORM, 0, 0, 0, 0, 0, ONE_Q16, ONE_Q16));
        wait_until_drained();
    endtask

    // Loads must not react to the vector fields, nor transforms to the load fields.
    task automatic test_ignored_fields();
        send_request(make_request(ACT_XFORM, 3, 3, LANE_MAX, ONE_Q16, ONE_Q16, ONE_Q16,
                                  ONE_Q16));
        send_request(make_request(ACT_LOAD, 2, 1, -1, -1, -1, -1, -1));
        send_request(make_request(ACT_XFORM, 3, 3, -1, -1, -1, -1, -1));
        wait_until_drained();
    endtask

    task automatic test_random_traffic(int count, int src_pct, int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int n = 0; n < count; n++) begin
            send_request(rand_request(35));
        end
        wait_until_drained();
    endtask

    initial begin
        for (int r = 0; r < NUM_LANES; r++) begin
            for (int c = 0; c < NUM_LANES; c++) begin
                matrix_coeff[r][c] = '0;
            end
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_cleared_store();
        test_extreme_products();
        test_ignored_fields();
        test_random_traffic(440, 0, 0);
        test_random_traffic(440, 61, 0);
        test_random_traffic(440, 0, 61);
        test_random_traffic(440, 34, 34);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
src/m4vt_pkg.sv
src/m4vt_store.sv
src/m4vt_mult_stage.sv
src/m4vt_sum_stage.sv
src/m4vt_sat_stage.sv
src/matrix4_vector_transform.sv
verif/tb_matrix4_vector_transform.sv
